// File: src/assert_macros.svh
// assert_macros.svh: assertion macros shared by the sine datapath files.
// No dependencies; define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Clocked check, switched off while the reset is asserted.
`define SDT_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// Clocked check that also holds during reset.
`define SDT_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define SDT_ASSERT(lbl, clk, rstn, prop, msg)
`define SDT_ASSERT_NR(lbl, clk, prop, msg)
`endif
`endif

// File: src/sdt_pkg.sv
// sdt_pkg: widths, constants, the term record and the divide-by-45 helper
// shared by the sine datapath. No dependencies.
package sdt_pkg;

  localparam int ANGLE_W = 32;
  localparam int SINE_W  = 32;

  // Range reduction on the Q8 degree value.
  localparam int DEG_FULL_Q8 = 92160;
  localparam int DEG_HALF_Q8 = 46080;
  localparam int FOLD_W      = 16;
  localparam int REM_W       = 17;
  localparam int QUOT_W      = 15;

  // Exact floor(v / 45) for any v below 2^21: multiply and shift.
  localparam int              DIV45_IN_W  = 21;
  localparam int              DIV45_OUT_W = 16;
  localparam int              DIV45_SHIFT = 27;
  localparam logic [21:0]     DIV45_M     = 22'd2982617;

  // pi in Q44, split as 45 * PI_DIV45_Q + PI_DIV45_R so that the degree to
  // radian scaling needs no wide divider.
  localparam logic [47:0] PI_Q44     = 48'h3243F6A8885A;
  localparam logic [47:0] PI_DIV45_Q = PI_Q44 / 48'd45;
  localparam logic [47:0] PI_DIV45_R = PI_Q44 % 48'd45;
  localparam int          PI_QL_W    = 24;
  localparam int          PI_QH_W    = 17;
  localparam int          PI_RC_W    = 6;
  localparam logic [PI_QL_W-1:0] PI_QL = PI_DIV45_Q[PI_QL_W-1:0];
  localparam logic [PI_QH_W-1:0] PI_QH = PI_DIV45_Q[PI_QL_W+PI_QH_W-1:PI_QL_W];
  localparam logic [PI_RC_W-1:0] PI_RC = PI_DIV45_R[PI_RC_W-1:0];

  // Datapath widths of the series.
  localparam int XM_W    = 32;
  localparam int X2_W    = 30;
  localparam int TERM_W  = 33;
  localparam int SUM_W   = 36;
  localparam int PROD_W  = TERM_W + X2_W;
  localparam int ROUND_SHIFT = 26;
  localparam int W_W     = 37;
  localparam int W_LO    = 18;
  localparam int KMAX_W  = 10;
  localparam int RCP_SHIFT = W_W + KMAX_W;
  localparam int RCP_W   = W_W + 8;
  localparam int R_LO    = 23;

  localparam logic signed [SUM_W-1:0] SUM_ONE     = SUM_W'(1073741824);
  localparam logic signed [SUM_W-1:0] SUM_NEG_ONE = -SUM_ONE;

  // One Taylor term in sign and magnitude form, with x^2 and the running sum.
  typedef struct packed {
    logic                    neg;
    logic [TERM_W-1:0]       mag;
    logic [X2_W-1:0]         x2;
    logic signed [SUM_W-1:0] sum;
  } term_t;

  function automatic logic [DIV45_OUT_W-1:0] div45(input logic [DIV45_IN_W-1:0] v);
    logic [DIV45_IN_W+21:0] p;
    p = (DIV45_IN_W+22)'(v) * (DIV45_IN_W+22)'(DIV45_M);
    return p[DIV45_SHIFT +: DIV45_OUT_W];
  endfunction

endpackage

// File: src/sdt_reduce.sv
// sdt_reduce: eight-stage front end that reduces the angle modulo 360
// degrees, folds it to +-180 and forms x and x^2. Uses sdt_pkg, assert_macros.svh.
`include "assert_macros.svh"

module sdt_reduce (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic signed [sdt_pkg::ANGLE_W-1:0] angle_deg_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output sdt_pkg::term_t                     out_term_o
);

  localparam int NS = 8;

  logic [NS-1:0] v_q, v_d, adv;

  // Stage payloads.
  logic                                  s0_neg_q, s1_neg_q, s2_neg_q, s3_neg_q;
  logic                                  s4_neg_q, s5_neg_q, s6_neg_q, s7_neg_q;
  logic [sdt_pkg::ANGLE_W-1:0]           s0_amag_q, s1_amag_q;
  logic [sdt_pkg::QUOT_W-1:0]            s1_quot_q;
  logic [sdt_pkg::REM_W-1:0]             s2_rem_q;
  logic [sdt_pkg::FOLD_W-1:0]            s3_mag_q;
  logic [sdt_pkg::FOLD_W+sdt_pkg::PI_QL_W-1:0] s4_pl_q, s5_pl_q;
  logic [sdt_pkg::FOLD_W+sdt_pkg::PI_QH_W-1:0] s4_ph_q, s5_ph_q;
  logic [sdt_pkg::DIV45_IN_W-1:0]        s4_pr_q;
  logic [sdt_pkg::DIV45_OUT_W-1:0]       s5_d_q;
  logic [sdt_pkg::XM_W-1:0]              s6_xm_q, s7_xm_q;

  logic [sdt_pkg::ANGLE_W-1:0] amag_d;
  logic [sdt_pkg::ANGLE_W-1:0] rem_full;
  logic                        fold_wrap;
  logic [56:0]                 xsum;
  logic [63:0]                 xsq;

  logic [sdt_pkg::X2_W-1:0] s7_x2_w;
  logic [63:0]              xsq_rnd;
  logic [sdt_pkg::X2_W-1:0] s7_x2_hold_q;

  always_comb begin
    adv[NS-1] = !v_q[NS-1] || out_ready_i;
    for (int i = NS - 2; i >= 0; i--) begin
      adv[i] = !v_q[i] || adv[i+1];
    end
    v_d[0] = adv[0] ? in_valid_i : v_q[0];
    for (int i = 1; i < NS; i++) begin
      v_d[i] = adv[i] ? v_q[i-1] : v_q[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign amag_d    = angle_deg_i[sdt_pkg::ANGLE_W-1] ?
                     (~angle_deg_i + sdt_pkg::ANGLE_W'(1)) : angle_deg_i;
  assign rem_full  = s1_amag_q -
                     (sdt_pkg::ANGLE_W'(s1_quot_q) * sdt_pkg::ANGLE_W'(sdt_pkg::DEG_FULL_Q8));
  assign fold_wrap = (s2_rem_q > sdt_pkg::REM_W'(sdt_pkg::DEG_HALF_Q8));
  assign xsum      = (57'(s5_ph_q) << sdt_pkg::PI_QL_W) + 57'(s5_pl_q) +
                     (57'(1) << (sdt_pkg::PI_QL_W - 1)) + 57'(s5_d_q);
  assign xsq       = 64'(s7_xm_q) * 64'(s7_xm_q);

  // Payload registers, loaded whenever their stage advances.
  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      s0_neg_q  <= angle_deg_i[sdt_pkg::ANGLE_W-1];
      s0_amag_q <= amag_d;
    end
    if (adv[1]) begin
      s1_neg_q  <= s0_neg_q;
      s1_amag_q <= s0_amag_q;
      s1_quot_q <= sdt_pkg::QUOT_W'(sdt_pkg::div45(s0_amag_q[sdt_pkg::ANGLE_W-1 -: 21]));
    end
    if (adv[2]) begin
      s2_neg_q <= s1_neg_q;
      s2_rem_q <= rem_full[sdt_pkg::REM_W-1:0];
    end
    if (adv[3]) begin
      s3_neg_q <= fold_wrap ? !s2_neg_q : s2_neg_q;
      s3_mag_q <= fold_wrap ?
                  sdt_pkg::FOLD_W'(sdt_pkg::REM_W'(sdt_pkg::DEG_FULL_Q8) - s2_rem_q) :
                  s2_rem_q[sdt_pkg::FOLD_W-1:0];
    end
    if (adv[4]) begin
      s4_neg_q <= s3_neg_q;
      s4_pl_q  <= (sdt_pkg::FOLD_W+sdt_pkg::PI_QL_W)'(s3_mag_q) *
                  (sdt_pkg::FOLD_W+sdt_pkg::PI_QL_W)'(sdt_pkg::PI_QL);
      s4_ph_q  <= (sdt_pkg::FOLD_W+sdt_pkg::PI_QH_W)'(s3_mag_q) *
                  (sdt_pkg::FOLD_W+sdt_pkg::PI_QH_W)'(sdt_pkg::PI_QH);
      s4_pr_q  <= sdt_pkg::DIV45_IN_W'(s3_mag_q) * sdt_pkg::DIV45_IN_W'(sdt_pkg::PI_RC);
    end
    if (adv[5]) begin
      s5_neg_q <= s4_neg_q;
      s5_pl_q  <= s4_pl_q;
      s5_ph_q  <= s4_ph_q;
      s5_d_q   <= sdt_pkg::div45(s4_pr_q);
    end
    if (adv[6]) begin
      s6_neg_q <= s5_neg_q;
      s6_xm_q  <= xsum[sdt_pkg::PI_QL_W +: sdt_pkg::XM_W];
    end
    if (adv[7]) begin
      s7_neg_q <= s6_neg_q;
      s7_xm_q  <= s6_xm_q;
    end
  end

  // x^2 is rounded from the squared stage-6 x and registered with x in the last stage.
  always_comb begin
    out_term_o.neg = s7_neg_q;
    out_term_o.mag = sdt_pkg::TERM_W'(s7_xm_q);
    out_term_o.x2  = s7_x2_w;
    out_term_o.sum = '0;
  end

  assign xsq_rnd = 64'(64'(s6_xm_q) * 64'(s6_xm_q)) + (64'd1 << 33);

  always_ff @(posedge clk_i) begin
    if (adv[7]) begin
      s7_x2_hold_q <= xsq_rnd[34 +: sdt_pkg::X2_W];
    end
  end

  assign s7_x2_w     = s7_x2_hold_q;
  assign in_ready_o  = adv[0];
  assign out_valid_o = v_q[NS-1];

  `SDT_ASSERT(a_rem_below_turn, clk_i, rst_ni, v_q[2] |-> (s2_rem_q < sdt_pkg::REM_W'(sdt_pkg::DEG_FULL_Q8)), "remainder not below a full turn")
  `SDT_ASSERT(a_fold_in_half, clk_i, rst_ni, v_q[3] |-> (s3_mag_q <= sdt_pkg::FOLD_W'(sdt_pkg::DEG_HALF_Q8)), "folded angle beyond 180 degrees")
  `SDT_ASSERT(a_x2_matches_x, clk_i, rst_ni, v_q[7] |-> (s7_x2_hold_q == xsq[34 +: sdt_pkg::X2_W] || xsq[63:34] == s7_x2_hold_q - 30'd1), "x squared out of step with x")

endmodule

// File: src/sdt_cell.sv
// sdt_cell: one Taylor step. Adds the incoming term to the running sum and
// derives the next term as -term * x^2 / (2n(2n+1)). Uses sdt_pkg.
module sdt_cell #(
  parameter int unsigned IDX = 1
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  sdt_pkg::term_t in_term_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output sdt_pkg::term_t out_term_o
);

  localparam int NS = 4;

  // Divisor 2n(2n+1) and its rounded-up reciprocal, exact for the w range.
  localparam logic [63:0] K         = 64'(2 * IDX * (2 * IDX + 1));
  localparam logic [63:0] ROUND_ADD = K << (sdt_pkg::ROUND_SHIFT - 1);
  localparam logic [63:0] RECIP     = ((64'd1 << sdt_pkg::RCP_SHIFT) + K - 64'd1) / K;
  localparam logic [sdt_pkg::RCP_W-1:0] RCP = RECIP[sdt_pkg::RCP_W-1:0];

  localparam int WH_W  = sdt_pkg::W_W - sdt_pkg::W_LO;
  localparam int MH_W  = sdt_pkg::RCP_W - sdt_pkg::R_LO;
  localparam int LL_W  = sdt_pkg::W_LO + sdt_pkg::R_LO;
  localparam int LH_W  = sdt_pkg::W_LO + MH_W;
  localparam int HL_W  = WH_W + sdt_pkg::R_LO;
  localparam int HH_W  = WH_W + MH_W;
  localparam int TOT_W = sdt_pkg::W_W + sdt_pkg::RCP_W;

  logic [NS-1:0] v_q, v_d, adv;

  logic                           c_neg_q [NS];
  logic [sdt_pkg::X2_W-1:0]       c_x2_q  [NS];
  logic signed [sdt_pkg::SUM_W-1:0] c_sum_q [NS];

  logic [sdt_pkg::PROD_W-1:0] c1_prod_q;
  logic [sdt_pkg::W_W-1:0]    c2_w_q;
  logic [LL_W-1:0]            c3_ll_q;
  logic [LH_W-1:0]            c3_lh_q;
  logic [HL_W-1:0]            c3_hl_q;
  logic [HH_W-1:0]            c3_hh_q;
  logic [sdt_pkg::TERM_W-1:0] c4_mag_q;

  logic signed [sdt_pkg::SUM_W-1:0] addend;
  logic [63:0]                      wsum;
  logic [TOT_W-1:0]                 tot;

  always_comb begin
    adv[NS-1] = !v_q[NS-1] || out_ready_i;
    for (int i = NS - 2; i >= 0; i--) begin
      adv[i] = !v_q[i] || adv[i+1];
    end
    v_d[0] = adv[0] ? in_valid_i : v_q[0];
    for (int i = 1; i < NS; i++) begin
      v_d[i] = adv[i] ? v_q[i-1] : v_q[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign addend = sdt_pkg::SUM_W'(in_term_i.mag);
  assign wsum   = 64'(c1_prod_q) + ROUND_ADD;
  assign tot    = TOT_W'(c3_ll_q) + (TOT_W'(c3_lh_q) << sdt_pkg::R_LO) +
                  (TOT_W'(c3_hl_q) << sdt_pkg::W_LO) +
                  (TOT_W'(c3_hh_q) << (sdt_pkg::W_LO + sdt_pkg::R_LO));

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      c_neg_q[0] <= !in_term_i.neg;
      c_x2_q[0]  <= in_term_i.x2;
      c_sum_q[0] <= in_term_i.sum + (in_term_i.neg ? -addend : addend);
      c1_prod_q  <= sdt_pkg::PROD_W'(in_term_i.mag) * sdt_pkg::PROD_W'(in_term_i.x2);
    end
    for (int i = 1; i < NS; i++) begin
      if (adv[i]) begin
        c_neg_q[i] <= c_neg_q[i-1];
        c_x2_q[i]  <= c_x2_q[i-1];
        c_sum_q[i] <= c_sum_q[i-1];
      end
    end
    if (adv[1]) begin
      c2_w_q <= wsum[sdt_pkg::ROUND_SHIFT +: sdt_pkg::W_W];
    end
    if (adv[2]) begin
      c3_ll_q <= LL_W'(c2_w_q[sdt_pkg::W_LO-1:0]) * LL_W'(RCP[sdt_pkg::R_LO-1:0]);
      c3_lh_q <= LH_W'(c2_w_q[sdt_pkg::W_LO-1:0]) * LH_W'(RCP[sdt_pkg::RCP_W-1:sdt_pkg::R_LO]);
      c3_hl_q <= HL_W'(c2_w_q[sdt_pkg::W_W-1:sdt_pkg::W_LO]) * HL_W'(RCP[sdt_pkg::R_LO-1:0]);
      c3_hh_q <= HH_W'(c2_w_q[sdt_pkg::W_W-1:sdt_pkg::W_LO]) *
                 HH_W'(RCP[sdt_pkg::RCP_W-1:sdt_pkg::R_LO]);
    end
    if (adv[3]) begin
      c4_mag_q <= tot[sdt_pkg::RCP_SHIFT +: sdt_pkg::TERM_W];
    end
  end

  always_comb begin
    out_term_o.neg = c_neg_q[NS-1];
    out_term_o.mag = c4_mag_q;
    out_term_o.x2  = c_x2_q[NS-1];
    out_term_o.sum = c_sum_q[NS-1];
  end

  assign in_ready_o  = adv[0];
  assign out_valid_o = v_q[NS-1];

endmodule

// File: src/sine_degrees_taylor.sv
// sine_degrees_taylor: top level of the sine-of-degrees datapath.
// Uses sdt_pkg, sdt_reduce, sdt_cell and assert_macros.svh.
//
//  Channel  Direction  Beat contents                     Handshake
//  s_axis   in         tdata[31:0] angle_deg, Q23.8      tvalid / tready
//  m_axis   out        tdata[31:0] sine_value, Q1.30     tvalid / tready
//
// One angle is taken per clock cycle and one sine leaves per cycle
// while m_axis_tready is high. The path is eight range-reduction
// stages, four stages in each Taylor cell, and the output register.
// The four-stage cell, with its split reciprocal multiply, sets the
// pipeline depth.
// Reset clears only the valid flags; the data registers are left alone.
// Every stage has its own valid flag and loads whenever it is empty or the
// stage after it moves, so bubbles close up and new beats are still taken
// while a finished result waits on m_axis.
`include "assert_macros.svh"

module sine_degrees_taylor #(
  parameter int unsigned TERM_COUNT = 9
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // [31:0] angle_deg
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o    // [31:0] sine_value
);

  // Link g carries term g+1 together with the sum of the terms before it.
  sdt_pkg::term_t          link_term [TERM_COUNT];
  logic [TERM_COUNT-1:0]   link_valid;
  logic [TERM_COUNT-1:0]   link_ready;

  logic                             out_v_q;
  logic [sdt_pkg::SINE_W-1:0]       out_data_q;
  logic                             out_adv;
  logic signed [sdt_pkg::SUM_W-1:0] last_term;
  logic signed [sdt_pkg::SUM_W-1:0] total;
  logic signed [sdt_pkg::SUM_W-1:0] clamped;

  // Front end: modulo 360, fold to +-180, scale to radians, square.
  sdt_reduce u_reduce (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .angle_deg_i ($signed(s_axis_tdata_i)),
    .out_valid_o (link_valid[0]),
    .out_ready_i (link_ready[0]),
    .out_term_o  (link_term[0])
  );

  // The row of Taylor cells; cell n turns term n into term n+1.
  for (genvar g = 1; g < TERM_COUNT; g++) begin : g_cell
    sdt_cell #(
      .IDX (g)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_valid_i  (link_valid[g-1]),
      .in_ready_o  (link_ready[g-1]),
      .in_term_i   (link_term[g-1]),
      .out_valid_o (link_valid[g]),
      .out_ready_i (link_ready[g]),
      .out_term_o  (link_term[g])
    );
  end

  // The last term joins the sum here, and the total is clamped to +-1.0.
  assign last_term = sdt_pkg::SUM_W'(link_term[TERM_COUNT-1].mag);
  assign total     = link_term[TERM_COUNT-1].sum +
                     (link_term[TERM_COUNT-1].neg ? -last_term : last_term);

  always_comb begin
    priority if (total > sdt_pkg::SUM_ONE) begin
      clamped = sdt_pkg::SUM_ONE;
    end else if (total < sdt_pkg::SUM_NEG_ONE) begin
      clamped = sdt_pkg::SUM_NEG_ONE;
    end else begin
      clamped = total;
    end
  end

  assign out_adv                = !out_v_q || m_axis_tready_i;
  assign link_ready[TERM_COUNT-1] = out_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_adv) begin
      out_v_q <= link_valid[TERM_COUNT-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_adv) begin
      out_data_q <= clamped[sdt_pkg::SINE_W-1:0];
    end
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = out_data_q;

  `SDT_ASSERT(a_out_in_range, clk_i, rst_ni, m_axis_tvalid_o |-> ($signed(m_axis_tdata_o) <= 32'sd1073741824 && $signed(m_axis_tdata_o) >= -32'sd1073741824), "sine outside +-1.0")
  `SDT_ASSERT(a_stall_only_backed_up, clk_i, rst_ni, !s_axis_tready_o |-> (m_axis_tvalid_o && !m_axis_tready_i), "input stalled with output free")
  `SDT_ASSERT_NR(a_no_result_in_reset, clk_i, !rst_ni |-> !m_axis_tvalid_o, "result shown during reset")

endmodule

// File: test/testbench.sv
// testbench: self-checking bench for sine_degrees_taylor, the sine of a Q23.8
// degree angle as Q1.30. It needs every file in src to compile.
// A scoreboard class predicts every sine and checks the returned beats in order.

module testbench;

  localparam int TERMS     = 9;
  localparam int LATENCY   = 8 + 4 * (TERMS - 1) + 1;
  localparam int IDLE_MAX  = 2000;
  localparam int RAND_A    = 450;
  localparam int HOLD_ITEMS = 150;
  localparam int RAND_B    = 550;
  localparam int BURST_ITEMS = 200;
  localparam int LONG_HOLD = 300;

  // Fixed-point constants of the prediction.
  localparam longint          FULL_TURN_Q8 = 92160;
  localparam longint          HALF_TURN_Q8 = 46080;
  localparam longint unsigned PI_Q44_C     = 64'h3243F6A8885A;
  localparam longint unsigned DEG_RAD_DIV  = 64'd180 << 22;
  localparam longint          ONE_Q30      = 64'sd1073741824;
  localparam int              RIGHT_Q8     = 23040;

  // Keeps the sines still owed by the block, oldest first, and checks each
  // beat that leaves it against the head of that queue.
  class sine_scoreboard;
    logic [31:0] owed_sines[$];
    int          mismatches;

    function new();
      mismatches = 0;
    endfunction

    // Reduce to -180..180 degrees, scale to Q30 radians, sum the series
    // term by term and clamp to plus or minus one.
    function automatic logic [31:0] predict_sine(logic [31:0] angle_bits);
      longint          rem_q8;
      longint unsigned rem_mag;
      longint unsigned x_mag;
      longint unsigned x_sq;
      longint unsigned den;
      longint unsigned prod_mag;
      longint unsigned quo;
      longint          term;
      longint          prod;
      longint          sum;
      int              n;
      rem_q8 = longint'($signed(angle_bits)) % FULL_TURN_Q8;
      if (rem_q8 > HALF_TURN_Q8) rem_q8 = rem_q8 - FULL_TURN_Q8;
      if (rem_q8 < -HALF_TURN_Q8) rem_q8 = rem_q8 + FULL_TURN_Q8;
      rem_mag = (rem_q8 < 0) ? longint'(-rem_q8) : rem_q8;
      x_mag = (rem_mag * PI_Q44_C + (DEG_RAD_DIV >> 1)) / DEG_RAD_DIV;
      x_sq = (x_mag * x_mag + (64'd1 << 33)) >> 34;
      term = (rem_q8 < 0) ? -longint'(x_mag) : longint'(x_mag);
      sum = 0;
      for (n = 1; n <= TERMS; n++) begin
        sum = sum + term;
        prod = term * longint'(x_sq);
        prod_mag = (prod < 0) ? 64'd0 - prod : prod;
        den = longint'(2 * n * (2 * n + 1)) << 26;
        quo = (prod_mag + (den >> 1)) / den;
        // Ties go away from zero on the magnitude; the sign flips each term.
        term = (prod < 0) ? longint'(quo) : -longint'(quo);
      end
      if (sum > ONE_Q30) sum = ONE_Q30;
      if (sum < -ONE_Q30) sum = -ONE_Q30;
      return sum[31:0];
    endfunction

    function void note_angle(logic [31:0] angle_bits);
      owed_sines.push_back(predict_sine(angle_bits));
    endfunction

    function void check_sine(logic [31:0] actual);
      logic [31:0] wanted;
      if (owed_sines.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: sine beat %h arrived with nothing owed", actual);
      end else begin
        wanted = owed_sines.pop_front();
        if (actual !== wanted) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: sine_value expected %h actual %h", wanted, actual);
        end
      end
    endfunction

    function int owed_count();
      return owed_sines.size();
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b1;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [31:0] s_axis_tdata_i = 32'd0;   // [31:0] angle_deg
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [31:0] m_axis_tdata_o;           // [31:0] sine_value

  sine_scoreboard sb;
  bit tx_idle_on = 1'b0;
  bit rx_idle_on = 1'b0;
  bit hold_req = 1'b0;

  sine_degrees_taylor #(.TERM_COUNT(TERMS)) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Mostly no gap or a short one, now and then a long one.
  function automatic int gap_length();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 88) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Random angle: the whole 32-bit range, small angles, and angles close to
  // the multiples of 90 degrees where the fold and the clamp act.
  function automatic logic [31:0] random_angle();
    int          kind;
    int          offset;
    longint      turns;
    longint      value;
    kind = $urandom_range(0, 9);
    if (kind < 4) return $urandom();
    if (kind < 6) return 32'($signed($urandom_range(0, 368640)) - 184320);
    offset = $signed($urandom_range(0, 512)) - 256;
    if (kind < 8) offset = $signed($urandom_range(0, 16)) - 8;
    turns = $signed($urandom_range(0, 20000)) - 10000;
    if ($urandom_range(0, 3) == 0) turns = 0;
    value = turns * FULL_TURN_Q8 + longint'($signed($urandom_range(0, 7)) - 3) * RIGHT_Q8
            + offset;
    return value[31:0];
  endfunction

  // Offers one angle beat and returns at the edge where it is taken. The
  // valid is only lowered when a gap is to be left before this beat.
  task automatic send_angle(input logic [31:0] angle_bits);
    int gap;
    gap = tx_idle_on ? gap_length() : 0;
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= angle_bits;
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_angle(angle_bits);
  endtask

  task automatic send_random(input int count);
    int k;
    for (k = 0; k < count; k++) send_angle(random_angle());
  endtask

  task automatic wait_drained();
    s_axis_tvalid_i <= 1'b0;
    while (sb.owed_count() != 0) @(posedge clk_i);
  endtask

  // Receiver: checks every beat taken and then sets tready for the next
  // edge. A long hold-off is counted out here, so the sender keeps offering
  // beats while the pipeline fills up behind the stalled output.
  initial begin : result_side
    int stall_left;
    int g;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid_o && m_axis_tready_i) sb.check_sine(m_axis_tdata_o);
      if (hold_req) begin
        stall_left = LONG_HOLD;
        hold_req = 1'b0;
      end
      if (stall_left > 0) begin
        m_axis_tready_i <= 1'b0;
        stall_left--;
      end else if (rx_idle_on) begin
        g = gap_length();
        if (g > 0) begin
          m_axis_tready_i <= 1'b0;
          stall_left = g - 1;
        end else begin
          m_axis_tready_i <= 1'b1;
        end
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  // Ends the run when neither side has moved a beat for too long.
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_MAX) begin
      @(posedge clk_i);
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("FAIL");
    $finish;
  end

  initial begin : stimulus
    logic [31:0] directed[$];
    int k;
    sb = new();
    directed = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'd7680, 32'd11520, 32'd23040,
                 -32'sd23040, 32'd23041, -32'sd23041, 32'd46079, -32'sd46079,
                 32'd46080, -32'sd46080, 32'd46081, -32'sd46081, 32'd69120,
                 -32'sd69120, 32'd92159, 32'd92160, -32'sd92160, 32'h7FFF_FFFF,
                 32'h8000_0000, 32'h7FFF_FF00, 32'hAAAA_AAAA, 32'h5555_5555};

    // The reset falls from a known high level, so the asynchronous clear
    // acts before the first clock edge.
    rst_ni <= 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed angles back to back with the receiver always ready.
    for (k = 0; k < directed.size(); k++) send_angle(directed[k]);

    // Random angles with gaps on both sides.
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    send_random(RAND_A);

    // Sender pauses until every owed sine has come back.
    wait_drained();

    // Long receiver hold-off while the sender streams without gaps, so the
    // pipeline fills and tready drops on the input side.
    tx_idle_on = 1'b0;
    hold_req = 1'b1;
    send_random(HOLD_ITEMS);

    tx_idle_on = 1'b1;
    send_random(RAND_B);

    // A stretch with no idling on either side.
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    send_random(BURST_ITEMS);

    wait_drained();
    repeat (LATENCY + 20) @(posedge clk_i);

    if (sb.mismatches == 0 && sb.owed_count() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+src
src/sdt_pkg.sv
src/sdt_reduce.sv
src/sdt_cell.sv
src/sine_degrees_taylor.sv
test/testbench.sv
